FILE: rtl/core/obst_pkg.sv
package obst_pkg;

  localparam int MAX_KEYS    = 32;
  localparam int WEIGHT_BITS = 16;
  localparam int KEY_W       = $clog2(MAX_KEYS);
  localparam int CNT_W       = KEY_W + 1;
  localparam int ADDR_W      = 2 * KEY_W;
  localparam int COST_W      = 26;
  localparam int SUM_W       = COST_W + 1;

  typedef struct packed {
    logic [15:0] weight;
    logic        last_key;
  } req_t;

  typedef struct packed {
    logic [25:0] min_cost;
    logic [5:0]  key_count;
    logic        overflowed;
  } res_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CELL,
    ST_STEP,
    ST_DRAIN,
    ST_FINAL
  } state_t;

  typedef struct packed {
    logic shift;
    logic append;
  } chain_ctl_t;

endpackage

FILE: rtl/core/optimal_bst_cost.sv
// Optimal binary search tree cost. Weights arrive one per request on start
// while busy is low; the request with last_key set starts the solve, which
// runs an interval recurrence row by row from the last key back to the first.
// The solve is paced by a single add-compare unit fed from the cost table
// memory and a recirculating chain of cells that holds the current row.
// busy drops in the cycle in which done pulses for one cycle with res valid,
// and the receiver must take it then as it cannot stall the block.
// Keys past MAX_KEYS are dropped and flagged in res.overflowed.
module optimal_bst_cost
  import obst_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output res_t res
);

  state_t state, state_next;

  logic [CNT_W-1:0]  count;
  logic              ovf;
  logic [KEY_W-1:0]  last_idx;
  logic [KEY_W-1:0]  row_i, col_j, r;
  logic [CNT_W-1:0]  qcnt;
  logic [SUM_W-1:0]  best;
  logic [SUM_W-1:0]  wsum;
  logic [COST_W-1:0] left_q;
  logic              rz_q;
  logic              pend_q;

  logic              accept;
  logic              w_we;
  logic [KEY_W-1:0]  w_raddr;
  logic [15:0]       w_rdata;
  logic              c_we;
  logic [ADDR_W-1:0] c_waddr, c_raddr;
  logic [COST_W-1:0] c_rdata;
  logic [COST_W-1:0] cell_val [MAX_KEYS];
  logic [COST_W-1:0] head;
  logic [COST_W-1:0] cost_new;
  logic [SUM_W-1:0]  cost_sum;
  logic [SUM_W-1:0]  cand;
  logic [15:0]       w_in;
  chain_ctl_t        ctl;
  logic              last_cell;

  assign accept    = start && !busy;
  assign busy      = (state != ST_LOAD);
  assign head      = cell_val[0];
  assign last_cell = (row_i == '0) && (col_j == last_idx);
  assign w_in      = 16'(req.weight[WEIGHT_BITS-1:0]);

  // weight store
  assign w_we    = accept && (count < CNT_W'(MAX_KEYS));
  assign w_raddr = col_j;
  obst_ram #(.WIDTH(16), .DEPTH(MAX_KEYS)) u_wram (
    .clk   (clk),
    .we    (w_we),
    .waddr (count[KEY_W-1:0]),
    .wdata (w_in),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  // cost table
  assign c_raddr = {r + KEY_W'(1), col_j};
  assign c_waddr = {row_i, col_j};
  obst_ram #(.WIDTH(COST_W), .DEPTH(MAX_KEYS * MAX_KEYS)) u_cram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (cost_new),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  // candidate sum and new interval cost
  assign cand     = SUM_W'(left_q) + (rz_q ? '0 : SUM_W'(c_rdata));
  assign cost_sum = best + wsum + SUM_W'(w_rdata);
  assign cost_new = cost_sum[SUM_W-1:COST_W] != '0 ? {COST_W{1'b1}} : cost_sum[COST_W-1:0];

  // row chain
  for (genvar k = 0; k < MAX_KEYS; k++) begin : g_cell
    logic [COST_W-1:0] nbr;
    if (k == MAX_KEYS - 1) begin : g_end
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_val[k+1];
    end
    obst_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .rot_sel (qcnt == CNT_W'(k + 1)),
      .app_sel (qcnt == CNT_W'(k)),
      .head    (head),
      .nbr     (nbr),
      .ins     (cost_new),
      .val     (cell_val[k])
    );
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:  if (accept && req.last_key) state_next = ST_CELL;
      ST_CELL:  state_next = ST_STEP;
      ST_STEP:  if (r == col_j) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_FINAL;
      ST_FINAL: state_next = last_cell ? ST_LOAD : ST_CELL;
      default:  state_next = ST_LOAD;
    endcase
  end

  // control strobes
  always_comb begin
    ctl.shift  = (state == ST_STEP) && (r != row_i);
    ctl.append = (state == ST_FINAL);
    c_we       = (state == ST_FINAL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      count <= '0;
      ovf   <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_FINAL) && last_cell;
      if (accept) begin
        if (count < CNT_W'(MAX_KEYS)) begin
          count <= count + CNT_W'(1);
        end else begin
          ovf <= 1'b1;
        end
      end
      if ((state == ST_FINAL) && last_cell) begin
        count <= '0;
        ovf   <= 1'b0;
      end
    end
  end

  // solve datapath
  always_ff @(posedge clk) begin
    pend_q <= (state == ST_STEP);
    if (pend_q && (cand < best)) begin
      best <= cand;
    end
    unique case (state)
      ST_LOAD: begin
        if (accept && req.last_key) begin
          if (count < CNT_W'(MAX_KEYS)) begin
            last_idx <= count[KEY_W-1:0];
          end else begin
            last_idx <= KEY_W'(MAX_KEYS - 1);
          end
          if (count < CNT_W'(MAX_KEYS)) begin
            row_i <= count[KEY_W-1:0];
            col_j <= count[KEY_W-1:0];
          end else begin
            row_i <= KEY_W'(MAX_KEYS - 1);
            col_j <= KEY_W'(MAX_KEYS - 1);
          end
          qcnt <= '0;
          wsum <= '0;
        end
      end
      ST_CELL: begin
        r    <= row_i;
        best <= {SUM_W{1'b1}};
      end
      ST_STEP: begin
        left_q <= (r == row_i) ? '0 : head;
        rz_q   <= (r == col_j);
        if (r != col_j) begin
          r <= r + KEY_W'(1);
        end
      end
      ST_DRAIN: begin
      end
      ST_FINAL: begin
        if (last_cell) begin
          res.min_cost   <= cost_new;
          res.key_count  <= 6'(32'(last_idx) + 1);
          res.overflowed <= ovf;
        end else if (col_j != last_idx) begin
          col_j <= col_j + KEY_W'(1);
          qcnt  <= qcnt + CNT_W'(1);
          wsum  <= wsum + SUM_W'(w_rdata);
        end else begin
          row_i <= row_i - KEY_W'(1);
          col_j <= row_i - KEY_W'(1);
          qcnt  <= '0;
          wsum  <= '0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/core/obst_ram.sv
module obst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/obst_cell.sv
module obst_cell
  import obst_pkg::*;
(
  input  logic              clk,
  input  chain_ctl_t        ctl,
  input  logic              rot_sel,
  input  logic              app_sel,
  input  logic [COST_W-1:0] head,
  input  logic [COST_W-1:0] nbr,
  input  logic [COST_W-1:0] ins,
  output logic [COST_W-1:0] val
);

  // shift towards the head, the tail cell takes the recirculated head
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      val <= rot_sel ? head : nbr;
    end else if (ctl.append && app_sel) begin
      val <= ins;
    end
  end

endmodule
